@@ src/qs_pkg.sv @@
// qs_pkg: shared types and constants for the quicksort engine
// no dependencies; used by qs_ctrl, qs_dp and quicksort_engine

package qs_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned DataW       = 32;

  // controller states
  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_RANGE,
    S_CHECK,
    S_PIVOT,
    S_SCAN_I,
    S_SCAN_K,
    S_SWAP,
    S_FINISH,
    S_FIN_HI,
    S_FIN_K,
    S_PUSH_HI,
    S_PUSH_LO,
    S_OUT_RD,
    S_OUT
  } state_e;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIVOT,
    OP_PIV_CAP,
    OP_STEP_I,
    OP_TO_K,
    OP_STEP_K,
    OP_SWAP_I,
    OP_SWAP_K,
    OP_FIN_RD,
    OP_FIN_HI,
    OP_FIN_K,
    OP_PUSH_HI,
    OP_PUSH_LO,
    OP_OUT_RD,
    OP_OUT_NEXT,
    OP_CLEAR
  } op_e;

  // status from datapath to controller
  typedef struct packed {
    logic stack_empty;
    logic range_ok;
    logic i_lt_k;
    logic elem_lt_pivot;
    logic hi_gt_k;
    logic push_hi_ok;
    logic push_lo_ok;
    logic out_last;
  } status_t;

endpackage

@@ src/quicksort_engine.sv @@
// quicksort_engine: top level, joins qs_ctrl and qs_dp
// depends on qs_pkg, qs_ctrl, qs_dp
//
// channel  | direction | ports
// input    | in        | start, busy, value_i, last_i
// result   | out       | strobe, sorted_value_o, final_res_o
//
// loading accepts elements back to back while busy is low. after the item
// flagged last the engine sets up the range stack; per popped range it loads
// and checks the bounds, takes the pivot, scans i up and k down, swaps pairs
// out of place and moves the pivot when needed, then pushes the sub-ranges;
// on an empty stack it reads the first element, then one result per cycle.
// reset clears counts and control; store contents stay undefined.
// the receiver cannot stall; busy stays high from the cycle after the last
// item through the cycle of the final result.

module quicksort_engine #(
  parameter int unsigned MAX_ELEMENTS = qs_pkg::MaxElements
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [qs_pkg::DataW-1:0] value_i,
  input  logic                            last_i,
  output logic                            strobe,
  output logic signed [qs_pkg::DataW-1:0] sorted_value_o,
  output logic                            final_res_o
);

  qs_pkg::op_e     op;
  qs_pkg::status_t st;
  logic [qs_pkg::DataW-1:0] data;

  qs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .last_i, .status_i(st),
    .op_o(op), .busy_o(busy), .strobe_o(strobe)
  );

  qs_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk_i, .rst_ni, .op_i(op), .value_i(value_i),
    .status_o(st), .data_o(data)
  );

  assign sorted_value_o = $signed(data);
  assign final_res_o    = strobe & st.out_last;

  // results only while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe |-> busy)
    else $error("result strobe while idle");
  // final result ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni) final_res_o |=> !busy)
    else $error("still busy after final result");
  // final flag only with strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) final_res_o |-> strobe)
    else $error("final flag without strobe");

endmodule

@@ src/qs_ctrl.sv @@
// qs_ctrl: controller state machine of the quicksort engine
// depends on qs_pkg

module qs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  qs_pkg::status_t   status_i,
  output qs_pkg::op_e       op_o,
  output logic              busy_o,
  output logic              strobe_o
);

  qs_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qs_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    op_o     = qs_pkg::OP_NONE;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    case (state_q)
      qs_pkg::S_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          op_o = qs_pkg::OP_LOAD;
          if (last_i) state_d = qs_pkg::S_INIT;
        end
      end
      qs_pkg::S_INIT: begin
        op_o    = qs_pkg::OP_INIT;
        state_d = qs_pkg::S_POP;
      end
      qs_pkg::S_POP: begin
        if (status_i.stack_empty) begin
          state_d = qs_pkg::S_OUT_RD;
        end else begin
          op_o    = qs_pkg::OP_POP;
          state_d = qs_pkg::S_RANGE;
        end
      end
      qs_pkg::S_RANGE: begin
        // stack entry registered; load lo/hi
        op_o    = qs_pkg::OP_RANGE;
        state_d = qs_pkg::S_CHECK;
      end
      qs_pkg::S_CHECK: begin
        if (status_i.range_ok) begin
          op_o    = qs_pkg::OP_PIVOT;
          state_d = qs_pkg::S_PIVOT;
        end else begin
          state_d = qs_pkg::S_POP;
        end
      end
      qs_pkg::S_PIVOT: begin
        op_o    = qs_pkg::OP_PIV_CAP;
        state_d = qs_pkg::S_SCAN_I;
      end
      qs_pkg::S_SCAN_I: begin
        // element at i is registered
        if (!status_i.i_lt_k) begin
          state_d = qs_pkg::S_FINISH;
        end else if (status_i.elem_lt_pivot) begin
          op_o = qs_pkg::OP_STEP_I;
        end else begin
          op_o    = qs_pkg::OP_TO_K;
          state_d = qs_pkg::S_SCAN_K;
        end
      end
      qs_pkg::S_SCAN_K: begin
        // element at k is registered
        if (!status_i.i_lt_k) begin
          state_d = qs_pkg::S_FINISH;
        end else if (!status_i.elem_lt_pivot) begin
          op_o = qs_pkg::OP_STEP_K;
        end else begin
          op_o    = qs_pkg::OP_SWAP_I;
          state_d = qs_pkg::S_SWAP;
        end
      end
      qs_pkg::S_SWAP: begin
        op_o    = qs_pkg::OP_SWAP_K;
        state_d = qs_pkg::S_SCAN_I;
      end
      qs_pkg::S_FINISH: begin
        if (status_i.hi_gt_k) begin
          op_o    = qs_pkg::OP_FIN_RD;
          state_d = qs_pkg::S_FIN_HI;
        end else begin
          state_d = qs_pkg::S_PUSH_HI;
        end
      end
      qs_pkg::S_FIN_HI: begin
        op_o    = qs_pkg::OP_FIN_HI;
        state_d = qs_pkg::S_FIN_K;
      end
      qs_pkg::S_FIN_K: begin
        op_o    = qs_pkg::OP_FIN_K;
        state_d = qs_pkg::S_PUSH_HI;
      end
      qs_pkg::S_PUSH_HI: begin
        if (status_i.push_hi_ok) op_o = qs_pkg::OP_PUSH_HI;
        state_d = qs_pkg::S_PUSH_LO;
      end
      qs_pkg::S_PUSH_LO: begin
        if (status_i.push_lo_ok) op_o = qs_pkg::OP_PUSH_LO;
        state_d = qs_pkg::S_POP;
      end
      qs_pkg::S_OUT_RD: begin
        op_o    = qs_pkg::OP_OUT_RD;
        state_d = qs_pkg::S_OUT;
      end
      qs_pkg::S_OUT: begin
        strobe_o = 1'b1;
        if (status_i.out_last) begin
          op_o    = qs_pkg::OP_CLEAR;
          state_d = qs_pkg::S_LOAD;
        end else begin
          op_o = qs_pkg::OP_OUT_NEXT;
        end
      end
      default: state_d = qs_pkg::S_LOAD;
    endcase
  end

endmodule

@@ src/qs_dp.sv @@
// qs_dp: element store, range stack, indexes and compare of the quicksort engine
// depends on qs_pkg

module qs_dp #(
  parameter int unsigned MAX_ELEMENTS = qs_pkg::MaxElements
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qs_pkg::op_e              op_i,
  input  logic [qs_pkg::DataW-1:0] value_i,
  output qs_pkg::status_t          status_o,
  output logic [qs_pkg::DataW-1:0] data_o
);

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned Dw = qs_pkg::DataW;

  logic [Dw-1:0]   mem [MAX_ELEMENTS];
  logic [2*AW-1:0] stk [MAX_ELEMENTS];

  logic [CW-1:0]   cnt_q, sp_q, cnt_d, sp_d;
  logic [AW-1:0]   lo_q, hi_q, i_q, k_q, oidx_q;
  logic [AW-1:0]   lo_d, hi_d, i_d, k_d, oidx_d;
  logic [Dw-1:0]   rd_q, piv_q, ai_q;
  logic [2*AW-1:0] srd_q;

  logic            we;
  logic [AW-1:0]   wa, ra;
  logic [Dw-1:0]   wd;
  logic            swe;
  logic [AW-1:0]   swa, sra;
  logic [2*AW-1:0] swd;
  logic [AW-1:0]   i_nx, k_nx, k_up, o_nx;
  logic            stk_room;

  assign i_nx     = i_q + AW'(1);
  assign k_nx     = k_q - AW'(1);
  assign k_up     = k_q + AW'(1);
  assign o_nx     = oidx_q + AW'(1);
  assign stk_room = sp_q < CW'(MAX_ELEMENTS);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sp_q <= '0;
      lo_q <= '0; hi_q <= '0; i_q <= '0; k_q <= '0; oidx_q <= '0;
    end else begin
      cnt_q <= cnt_d; sp_q <= sp_d;
      lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d; k_q <= k_d; oidx_q <= oidx_d;
    end
  end

  // command decode
  always_comb begin
    cnt_d = cnt_q; sp_d = sp_q; lo_d = lo_q; hi_d = hi_q; i_d = i_q; k_d = k_q;
    oidx_d = oidx_q;
    we = 1'b0; wa = i_q; wd = rd_q; ra = i_q;
    swe = 1'b0; swa = AW'(sp_q); swd = '0; sra = AW'(sp_q);
    case (op_i)
      qs_pkg::OP_LOAD: begin
        if (cnt_q < CW'(MAX_ELEMENTS)) begin
          we = 1'b1; wa = AW'(cnt_q); wd = value_i;
          cnt_d = cnt_q + CW'(1);
        end
      end
      qs_pkg::OP_INIT: begin
        sp_d = '0;
        if (cnt_q > CW'(1)) begin
          swe = 1'b1; swa = '0;
          swd = {AW'(0), AW'(cnt_q - CW'(1))};
          sp_d = CW'(1);
        end
      end
      qs_pkg::OP_POP: begin
        sp_d = sp_q - CW'(1);
        sra  = AW'(sp_q - CW'(1));
      end
      qs_pkg::OP_RANGE: begin
        lo_d = srd_q[2*AW-1:AW]; hi_d = srd_q[AW-1:0];
      end
      qs_pkg::OP_PIVOT: begin
        ra = hi_q; i_d = lo_q; k_d = hi_q;
      end
      qs_pkg::OP_PIV_CAP: ra = i_q;
      qs_pkg::OP_STEP_I: begin
        i_d = i_nx; ra = i_nx;
      end
      qs_pkg::OP_TO_K:  ra = k_q;
      qs_pkg::OP_STEP_K: begin
        k_d = k_nx; ra = k_nx;
      end
      qs_pkg::OP_SWAP_I: begin
        we = 1'b1; wa = i_q; wd = rd_q;
      end
      qs_pkg::OP_SWAP_K: begin
        we = 1'b1; wa = k_q; wd = ai_q; ra = i_q;
      end
      qs_pkg::OP_FIN_RD: ra = k_q;
      qs_pkg::OP_FIN_HI: begin
        we = 1'b1; wa = hi_q; wd = rd_q;
      end
      qs_pkg::OP_FIN_K: begin
        we = 1'b1; wa = k_q; wd = piv_q;
      end
      qs_pkg::OP_PUSH_HI: begin
        if (stk_room) begin
          swe = 1'b1; swd = {k_up, hi_q};
          sp_d = sp_q + CW'(1);
        end
      end
      qs_pkg::OP_PUSH_LO: begin
        if (stk_room) begin
          swe = 1'b1; swd = {lo_q, k_nx};
          sp_d = sp_q + CW'(1);
        end
      end
      qs_pkg::OP_OUT_RD: begin
        ra = '0; oidx_d = '0;
      end
      qs_pkg::OP_OUT_NEXT: begin
        oidx_d = o_nx; ra = o_nx;
      end
      qs_pkg::OP_CLEAR: begin
        cnt_d = '0; sp_d = '0;
      end
      default: ;
    endcase
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // range stack, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (swe) stk[swa] <= swd;
    srd_q <= stk[sra];
  end

  // pivot kept for the compares and the finish, element at i kept for the swap
  always_ff @(posedge clk_i) begin
    if (op_i == qs_pkg::OP_PIV_CAP) piv_q <= rd_q;
    if (op_i == qs_pkg::OP_TO_K)    ai_q  <= rd_q;
  end

  assign data_o = rd_q;

  // status flags
  always_comb begin
    status_o               = '0;
    status_o.stack_empty   = (sp_q == '0);
    status_o.range_ok      = (lo_q < hi_q) && (CW'(hi_q) < cnt_q);
    status_o.i_lt_k        = i_q < k_q;
    status_o.elem_lt_pivot = $signed(rd_q) < $signed(piv_q);
    status_o.hi_gt_k       = hi_q > k_q;
    status_o.push_hi_ok    = ({1'b0, k_q} + (AW+1)'(1)) < {1'b0, hi_q};
    status_o.push_lo_ok    = ({1'b0, lo_q} + (AW+1)'(1)) < {1'b0, k_q};
    status_o.out_last      = (CW'(oidx_q) + CW'(1)) >= cnt_q;
  end

endmodule
